/* hw/rtl/etf_pkg.sv */
// Shared types, constants and helpers for the escape-time fractal pixel block.
`timescale 1ns / 1ps
package etf_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_BITS   = 28;
    localparam int PIX_W       = 10;
    localparam int PITCH_W     = 14;
    localparam int OFFSET_W    = 24;
    localparam int COUNT_W     = 7;
    localparam int COLOR_W     = 24;
    localparam int BYTES_PER_PIXEL = 4;

    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 64;

    // divider: unsigned |span| (33 bits) times pixel coordinate
    localparam int SPAN_W      = DATA_W + 1;
    localparam int DIV_W       = SPAN_W + PIX_W;
    // image sizes and iteration counts go up to 4096; x / d is taken as
    // x * ceil(2^56 / d) >> 56, exact for every dividend below 2^43
    localparam int RECIP_SHIFT = 56;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic signed [63:0] ESCAPE_LIMIT = 64'sd1 <<< 30;
    localparam logic [COLOR_W-1:0] COLOR_FULL   = 24'hFFFFFF;
    localparam logic [DATA_W-1:0]  COLOR_BLACK  = 32'h000000;

    localparam int MB_SHIFT_HI = 21;
    localparam int MB_SHIFT_MD = 10;
    localparam int MB_SHIFT_LO = 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SET_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH = 3'd7;

    localparam logic MODE_MANDELBROT = 1'b0;
    localparam logic MODE_JULIA      = 1'b1;

    // divider operand selection
    localparam logic [1:0] DIV_SEL_RE    = 2'd0;
    localparam logic [1:0] DIV_SEL_IM    = 2'd1;
    localparam logic [1:0] DIV_SEL_COLOR = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       div_start;
        logic [1:0] div_sel;
        logic       load_re;
        logic       load_im;
        logic       init_z;
        logic       load_prod;
        logic       update_z;
        logic       inc_n;
        logic       load_color;
        logic       load_out;
    } etf_cmd_t;

    typedef struct packed {
        logic mode;
        logic div_done;
        logic escape;
        logic n_max;
        logic n_last;
    } etf_status_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/escape_time_fractal_pixel.sv */
// Escape-time fractal pixel engine (Mandelbrot / Julia) in signed Q4.28: top level.
//
// Each input transaction carries one pixel coordinate; the block maps it into the
// configured complex window, iterates z = z^2 + c and returns one transaction with the
// colour word, the iteration count and the pixel's byte offset. One pixel is in work at
// a time. In Mandelbrot mode a pixel with n iterations takes n + 1 passes, each of which
// registers the products, then updates z and tests for escape; Julia mode adds a
// division for the colour scaling. The two window mappings and the Julia colour share
// one constant-divisor unit that multiplies by a reciprocal as a sum of partial
// products. A finished result sits in an output register so the next pixel can be
// accepted while it waits; a second finished result holds until that register frees up.
// Configuration writes are always accepted and must only be issued while idle.
`timescale 1ns / 1ps
module escape_time_fractal_pixel #(
    parameter int IMAGE_WIDTH    = 800,
    parameter int IMAGE_HEIGHT   = 600,
    parameter int MAX_ITERATIONS = 100
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [etf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [etf_pkg::DATA_W-1:0]    cfg_data,
    // pixel input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [etf_pkg::S_TDATA_W-1:0] s_tdata,  // pixel_x[9:0], pixel_y[19:10]
    // result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [etf_pkg::M_TDATA_W-1:0] m_tdata   // pixel_word[31:0],
                                                    // iteration_count[38:32],
                                                    // pixel_offset[62:39]
);
    import etf_pkg::*;

    etf_cmd_t    cmd;
    etf_status_t status;
    logic        cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    etf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    etf_dp #(
        .IMAGE_WIDTH    (IMAGE_WIDTH),
        .IMAGE_HEIGHT   (IMAGE_HEIGHT),
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* hw/rtl/etf_div.sv */
// Constant-divisor unit: multiplies by a scaled reciprocal, summing partial products.
`timescale 1ns / 1ps
module etf_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [etf_pkg::DIV_W-1:0]   dividend,
    input  logic [etf_pkg::RECIP_W-1:0] recip,
    output logic                        done,
    output logic [etf_pkg::DIV_W-1:0]   quotient
);
    import etf_pkg::*;

    // dividend in two 22-bit chunks, reciprocal in three 19-bit chunks
    localparam int XC_W  = 22;
    localparam int MC_W  = 19;
    localparam int PP_W  = XC_W + MC_W;
    // x * recip stays below 2^99, so the top bits of the sum are never needed
    localparam int ACC_W = RECIP_SHIFT + DIV_W;
    localparam logic [2:0] LAST_STEP = 3'd5;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [2:0]        step_reg, step_next;
    logic [2*XC_W-1:0] x_reg, x_next;
    logic [3*MC_W-1:0] m_reg, m_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;

    logic [XC_W-1:0]   x_part;
    logic [MC_W-1:0]   m_part;
    logic [6:0]        m_shift;
    logic [6:0]        pp_shift;
    logic [PP_W-1:0]   pp;
    logic [ACC_W-1:0]  pp_aligned;

    always_comb begin
        x_part = step_reg[0] ? x_reg[2*XC_W-1:XC_W] : x_reg[XC_W-1:0];
        unique case (step_reg[2:1])
            2'd0: begin
                m_part  = m_reg[MC_W-1:0];
                m_shift = 7'd0;
            end
            2'd1: begin
                m_part  = m_reg[2*MC_W-1:MC_W];
                m_shift = 7'(MC_W);
            end
            2'd2: begin
                m_part  = m_reg[3*MC_W-1:2*MC_W];
                m_shift = 7'(2 * MC_W);
            end
            default: begin
                m_part  = '0;
                m_shift = 7'd0;
            end
        endcase
        pp_shift   = m_shift + (step_reg[0] ? 7'(XC_W) : 7'd0);
        pp         = PP_W'(x_part) * PP_W'(m_part);
        pp_aligned = ACC_W'(pp) << pp_shift;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            x_next    = (2*XC_W)'(dividend);
            m_next    = recip;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next  = acc_reg + pp_aligned;
            step_next = step_reg + 3'd1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg[ACC_W-1:RECIP_SHIFT];

endmodule

/* hw/rtl/etf_ctrl.sv */
// Sequencer for mapping, escape iteration, colouring and result handoff.
`timescale 1ns / 1ps
module etf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  etf_pkg::etf_status_t status,
    output etf_pkg::etf_cmd_t    cmd
);
    import etf_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_RE_START   = 4'd1;
    localparam logic [3:0] S_RE_WAIT    = 4'd2;
    localparam logic [3:0] S_IM_START   = 4'd3;
    localparam logic [3:0] S_IM_WAIT    = 4'd4;
    localparam logic [3:0] S_INIT       = 4'd5;
    localparam logic [3:0] S_JMUL       = 4'd6;
    localparam logic [3:0] S_JFIRST     = 4'd7;
    localparam logic [3:0] S_MUL        = 4'd8;
    localparam logic [3:0] S_EVAL       = 4'd9;
    localparam logic [3:0] S_COLOR      = 4'd10;
    localparam logic [3:0] S_COLOR_WAIT = 4'd11;
    localparam logic [3:0] S_FINISH     = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_RE_START;
                end
            end
            S_RE_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_RE;
                state_next    = S_RE_WAIT;
            end
            S_RE_WAIT: begin
                if (status.div_done) begin
                    cmd.load_re = 1'b1;
                    state_next  = S_IM_START;
                end
            end
            S_IM_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_IM;
                state_next    = S_IM_WAIT;
            end
            S_IM_WAIT: begin
                if (status.div_done) begin
                    cmd.load_im = 1'b1;
                    state_next  = S_INIT;
                end
            end
            S_INIT: begin
                cmd.init_z = 1'b1;
                state_next = (status.mode == MODE_JULIA) ? S_JMUL : S_MUL;
            end
            S_JMUL: begin
                cmd.load_prod = 1'b1;
                state_next    = S_JFIRST;
            end
            S_JFIRST: begin
                // first Julia update has no escape test in front of it
                cmd.update_z = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL: begin
                cmd.load_prod = 1'b1;
                state_next    = S_EVAL;
            end
            S_EVAL: begin
                if (status.mode == MODE_JULIA) begin
                    if (status.escape) begin
                        state_next = S_COLOR;
                    end else begin
                        cmd.inc_n = 1'b1;
                        if (status.n_last) begin
                            state_next = S_COLOR;
                        end else begin
                            cmd.update_z = 1'b1;
                            state_next   = S_MUL;
                        end
                    end
                end else begin
                    if (status.n_max || status.escape) begin
                        state_next = S_COLOR;
                    end else begin
                        cmd.update_z = 1'b1;
                        cmd.inc_n    = 1'b1;
                        state_next   = S_MUL;
                    end
                end
            end
            S_COLOR: begin
                if (status.mode == MODE_JULIA) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_COLOR;
                    state_next    = S_COLOR_WAIT;
                end else begin
                    cmd.load_color = 1'b1;
                    state_next     = S_FINISH;
                end
            end
            S_COLOR_WAIT: begin
                if (status.div_done) begin
                    cmd.load_color = 1'b1;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

/* hw/rtl/etf_dp.sv */
// Datapath: settings, coordinate mapping, z iteration, colour and result register.
`timescale 1ns / 1ps
module etf_dp #(
    parameter int IMAGE_WIDTH    = 800,
    parameter int IMAGE_HEIGHT   = 600,
    parameter int MAX_ITERATIONS = 100
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [etf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [etf_pkg::DATA_W-1:0]      cfg_data,
    input  logic [etf_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic [etf_pkg::M_TDATA_W-1:0]   m_tdata,
    input  etf_pkg::etf_cmd_t               cmd,
    output etf_pkg::etf_status_t            status
);
    import etf_pkg::*;

    localparam int N_W = $clog2(MAX_ITERATIONS + 1);
    localparam int CP_W = COLOR_W + N_W;

    // ceil(2^56 / d) for each constant divisor
    localparam logic [RECIP_W-1:0] RECIP_COL  =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(IMAGE_WIDTH - 1)) / 64'(IMAGE_WIDTH));
    localparam logic [RECIP_W-1:0] RECIP_ROW  =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(IMAGE_HEIGHT - 1)) / 64'(IMAGE_HEIGHT));
    localparam logic [RECIP_W-1:0] RECIP_ITER =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MAX_ITERATIONS - 1)) / 64'(MAX_ITERATIONS));

    // settings
    logic signed [DATA_W-1:0] real_min_reg, real_max_reg, imag_min_reg, imag_max_reg;
    logic signed [DATA_W-1:0] julia_re_reg, julia_im_reg;
    logic                     mode_reg;
    logic [PITCH_W-1:0]       pitch_reg;

    // per-pixel state
    logic [PIX_W-1:0]         px_reg, py_reg;
    logic signed [DATA_W-1:0] pr_reg, pi_reg;
    logic signed [DATA_W-1:0] zr_reg, zi_reg;
    logic signed [63:0]       prod_rr_reg, prod_ii_reg, prod_ri_reg;
    logic [N_W-1:0]           n_reg;
    logic                     neg_reg;
    logic [DATA_W-1:0]        word_reg;
    logic [M_TDATA_W-1:0]     out_reg;

    // divider
    logic                 div_done;
    logic [DIV_W-1:0]     div_q;
    logic [DIV_W-1:0]     div_dividend;
    logic [RECIP_W-1:0]   div_recip;
    logic                 neg_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_min_reg <= -32'sd536870912;
            real_max_reg <= 32'sd268435456;
            imag_min_reg <= -32'sd402653184;
            imag_max_reg <= 32'sd402653184;
            mode_reg     <= MODE_MANDELBROT;
            julia_re_reg <= '0;
            julia_im_reg <= '0;
            pitch_reg    <= 14'd3200;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_REAL_MIN:   real_min_reg <= cfg_data;
                REG_REAL_MAX:   real_max_reg <= cfg_data;
                REG_IMAG_MIN:   imag_min_reg <= cfg_data;
                REG_IMAG_MAX:   imag_max_reg <= cfg_data;
                REG_SET_MODE:   mode_reg     <= cfg_data[0];
                REG_JULIA_RE:   julia_re_reg <= cfg_data;
                REG_JULIA_IM:   julia_im_reg <= cfg_data;
                REG_LINE_PITCH: pitch_reg    <= cfg_data[PITCH_W-1:0];
            endcase
        end
    end

    // ---- mapping: (max - min) * p, magnitude into the divider ----
    logic signed [SPAN_W-1:0] span_re, span_im, span_sel;
    logic [SPAN_W-1:0]        span_mag;
    logic [PIX_W-1:0]         p_sel;
    logic [DIV_W-1:0]         map_prod;
    logic [CP_W-1:0]          color_prod;

    always_comb begin
        span_re    = SPAN_W'(real_max_reg) - SPAN_W'(real_min_reg);
        span_im    = SPAN_W'(imag_max_reg) - SPAN_W'(imag_min_reg);
        span_sel   = (cmd.div_sel == DIV_SEL_IM) ? span_im : span_re;
        p_sel      = (cmd.div_sel == DIV_SEL_IM) ? py_reg : px_reg;
        span_mag   = span_sel[SPAN_W-1] ? SPAN_W'(-span_sel) : SPAN_W'(span_sel);
        map_prod   = {{PIX_W{1'b0}}, span_mag} * {{SPAN_W{1'b0}}, p_sel};
        color_prod = {{N_W{1'b0}}, COLOR_FULL} * {{COLOR_W{1'b0}}, n_reg};
        neg_next   = neg_reg;
        unique case (cmd.div_sel)
            DIV_SEL_RE, DIV_SEL_IM: begin
                div_dividend = map_prod;
                div_recip    = (cmd.div_sel == DIV_SEL_IM) ? RECIP_ROW : RECIP_COL;
                if (cmd.div_start) begin
                    neg_next = span_sel[SPAN_W-1];
                end
            end
            DIV_SEL_COLOR: begin
                div_dividend = DIV_W'(color_prod);
                div_recip    = RECIP_ITER;
                if (cmd.div_start) begin
                    neg_next = 1'b0;
                end
            end
            default: begin
                div_dividend = '0;
                div_recip    = RECIP_COL;
            end
        endcase
    end

    etf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .recip    (div_recip),
        .done     (div_done),
        .quotient (div_q)
    );

    // quotient truncates toward zero: divide the magnitude, then restore the sign
    logic signed [DIV_W+1:0]  map_q, map_off, map_sum;
    logic signed [DATA_W-1:0] map_lo, map_val;

    always_comb begin
        map_q   = {2'b00, div_q};
        map_off = neg_reg ? -map_q : map_q;
        map_lo  = cmd.load_im ? imag_min_reg : real_min_reg;
        map_sum = (DIV_W+2)'(map_lo) + map_off;
        map_val = sat32(64'(map_sum));
    end

    // ---- iteration ----
    logic signed [63:0]       r2, i2, ri, mag;
    logic signed [DATA_W-1:0] c_re, c_im, nzr, nzi;

    always_comb begin
        r2   = prod_rr_reg >>> FRAC_BITS;
        i2   = prod_ii_reg >>> FRAC_BITS;
        ri   = prod_ri_reg >>> (FRAC_BITS - 1);
        mag  = r2 + i2;
        c_re = (mode_reg == MODE_JULIA) ? julia_re_reg : pr_reg;
        c_im = (mode_reg == MODE_JULIA) ? julia_im_reg : pi_reg;
        nzr  = sat32(r2 - i2 + 64'(c_re));
        nzi  = sat32(ri + 64'(c_im));
    end

    always_comb begin
        status.mode     = mode_reg;
        status.div_done = div_done;
        status.escape   = (mode_reg == MODE_JULIA) ? (mag >= ESCAPE_LIMIT)
                                                   : (mag > ESCAPE_LIMIT);
        status.n_max    = (n_reg == N_W'(MAX_ITERATIONS));
        status.n_last   = (n_reg == N_W'(MAX_ITERATIONS - 1));
    end

    // ---- colour and result ----
    logic [DATA_W-1:0]    n32, mb_word, color_word;
    logic [OFFSET_W:0]    offset_full;

    always_comb begin
        n32        = DATA_W'(n_reg);
        mb_word    = (n32 << MB_SHIFT_HI) | (n32 << MB_SHIFT_MD) | (n32 << MB_SHIFT_LO);
        if (mode_reg == MODE_JULIA) begin
            color_word = status.n_max ? COLOR_BLACK : div_q[DATA_W-1:0];
        end else begin
            color_word = mb_word;
        end
        offset_full = (OFFSET_W+1)'({{PITCH_W{1'b0}}, py_reg} * {{PIX_W{1'b0}}, pitch_reg})
                    + (OFFSET_W+1)'(px_reg * BYTES_PER_PIXEL);
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        if (cmd.load_in) begin
            px_reg <= s_tdata[PIX_W-1:0];
            py_reg <= s_tdata[2*PIX_W-1:PIX_W];
        end
        if (cmd.load_re) begin
            pr_reg <= map_val;
        end
        if (cmd.load_im) begin
            pi_reg <= map_val;
        end
        if (cmd.init_z) begin
            zr_reg <= (mode_reg == MODE_JULIA) ? pr_reg : '0;
            zi_reg <= (mode_reg == MODE_JULIA) ? pi_reg : '0;
            n_reg  <= '0;
        end else begin
            if (cmd.update_z) begin
                zr_reg <= nzr;
                zi_reg <= nzi;
            end
            if (cmd.inc_n) begin
                n_reg <= n_reg + 1'b1;
            end
        end
        if (cmd.load_prod) begin
            prod_rr_reg <= 64'(zr_reg) * 64'(zr_reg);
            prod_ii_reg <= 64'(zi_reg) * 64'(zi_reg);
            prod_ri_reg <= 64'(zr_reg) * 64'(zi_reg);
        end
        if (cmd.load_color) begin
            word_reg <= color_word;
        end
        if (cmd.load_out) begin
            out_reg <= {1'b0, offset_full[OFFSET_W-1:0], COUNT_W'(n_reg), word_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule
